// ===== hdl/udiv128_pkg.sv =====
// Package for the 128-by-32 unsigned divider.
// Shared widths, pipeline depth and the stage payload type.
package udiv128_pkg;

   localparam int DIVIDEND_W     = 128;
   localparam int HALF_W         = 64;
   localparam int DIVISOR_W      = 32;
   localparam int BITS_PER_STAGE = 4;
   localparam int NUM_STAGES     = DIVIDEND_W / BITS_PER_STAGE;

   typedef struct packed {
      logic                  valid;
      logic [DIVISOR_W-1:0]  divisor;
      logic [DIVISOR_W-1:0]  remainder;
      logic [DIVIDEND_W-1:0] num;      // dividend bits shift out, quotient bits shift in
   } stage_type;

endpackage

// ===== hdl/udiv128_stage.sv =====
// One pipeline stage of the restoring divider: BITS_PER_STAGE quotient bits.
// Depends on udiv128_pkg.
module udiv128_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  udiv128_pkg::stage_type up_stage,
   output udiv128_pkg::stage_type stage_ff
);

   udiv128_pkg::stage_type stage_in;

   always_comb begin
      logic [udiv128_pkg::DIVISOR_W-1:0]  rem;
      logic [udiv128_pkg::DIVIDEND_W-1:0] num;
      logic [udiv128_pkg::DIVISOR_W:0]    partial;
      logic [udiv128_pkg::DIVISOR_W:0]    diff;
      logic                               qbit;
      rem = up_stage.remainder;
      num = up_stage.num;
      for (int i = 0; i < udiv128_pkg::BITS_PER_STAGE; i++) begin
         partial = {rem, num[udiv128_pkg::DIVIDEND_W-1]};
         diff    = partial - {1'b0, up_stage.divisor};
         qbit    = ~diff[udiv128_pkg::DIVISOR_W];
         rem     = qbit ? diff[udiv128_pkg::DIVISOR_W-1:0]
                        : partial[udiv128_pkg::DIVISOR_W-1:0];
         num     = {num[udiv128_pkg::DIVIDEND_W-2:0], qbit};
      end
      stage_in.valid     = up_stage.valid;
      stage_in.divisor   = up_stage.divisor;
      stage_in.remainder = rem;
      stage_in.num       = num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.divisor   <= stage_in.divisor;
      stage_ff.remainder <= stage_in.remainder;
      stage_ff.num       <= stage_in.num;
   end

   a_valid_moves: assert property (@(posedge clock) disable iff (reset)
      up_stage.valid |=> stage_ff.valid)
      else $error("item lost in divider stage");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !up_stage.valid |=> !stage_ff.valid)
      else $error("item invented in divider stage");

   a_divisor_kept: assert property (@(posedge clock) disable iff (reset)
      up_stage.valid |=> stage_ff.divisor == $past(up_stage.divisor))
      else $error("divisor changed across stage");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (up_stage.valid && up_stage.divisor != '0 && up_stage.remainder < up_stage.divisor)
      |=> stage_ff.remainder < stage_ff.divisor)
      else $error("partial remainder not below divisor");

endmodule

// ===== hdl/uint128_divide_by_u32_core.sv =====
// Top level of the pipelined unsigned 128-by-32 divider.
// Depends on udiv128_pkg and udiv128_stage.
//
//  channel  ports                                          handshake
//  request  req_dividend_high/low, req_divisor             start & !busy
//  response rsp_quotient_high/low, rsp_remainder,          rsp_valid, one cycle
//           rsp_divide_by_zero
//
// Throughput one item per cycle; the pipeline depth NUM_STAGES = 32 is set by the
// restoring subtract chain at BITS_PER_STAGE = 4 quotient bits per stage.
// Synchronous reset clears the stage valid bits; payload is not reset.
// busy stays low: the pipeline never stalls and the receiver cannot stall.
module uint128_divide_by_u32_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [udiv128_pkg::HALF_W-1:0]    req_dividend_high,
   input  logic [udiv128_pkg::HALF_W-1:0]    req_dividend_low,
   input  logic [udiv128_pkg::DIVISOR_W-1:0] req_divisor,
   output logic                             rsp_valid,
   output logic [udiv128_pkg::HALF_W-1:0]    rsp_quotient_high,
   output logic [udiv128_pkg::HALF_W-1:0]    rsp_quotient_low,
   output logic [udiv128_pkg::DIVISOR_W-1:0] rsp_remainder,
   output logic                             rsp_divide_by_zero
);

   udiv128_pkg::stage_type chain [0:udiv128_pkg::NUM_STAGES];
   udiv128_pkg::stage_type last;
   logic                   zero_div;

   assign busy = 1'b0;

   always_comb begin
      chain[0].valid     = start & ~busy;
      chain[0].divisor   = req_divisor;
      chain[0].remainder = '0;
      chain[0].num       = {req_dividend_high, req_dividend_low};
   end

   for (genvar s = 0; s < udiv128_pkg::NUM_STAGES; s++) begin : g_stage
      udiv128_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_stage (chain[s]),
         .stage_ff (chain[s+1])
      );
   end

   assign last     = chain[udiv128_pkg::NUM_STAGES];
   assign zero_div = (last.divisor == '0);

   assign rsp_valid          = last.valid;
   assign rsp_divide_by_zero = zero_div;
   assign rsp_quotient_high  = zero_div ? '0
                             : last.num[udiv128_pkg::DIVIDEND_W-1:udiv128_pkg::HALF_W];
   assign rsp_quotient_low   = zero_div ? '0 : last.num[udiv128_pkg::HALF_W-1:0];
   assign rsp_remainder      = zero_div ? '0 : last.remainder;

endmodule
